// ===== rtl/smbseq_pkg.sv =====
// Shared types and codes for the SMBus master transfer sequencer.
// No dependencies; imported by smbseq_step and smbus_master_transfer_sequencer.
package smbseq_pkg;

  // Input transaction commands.
  localparam logic [1:0] CMD_LOAD       = 2'd0;
  localparam logic [1:0] CMD_START_WR   = 2'd1;
  localparam logic [1:0] CMD_START_RD   = 2'd2;
  localparam logic [1:0] CMD_STATUS     = 2'd3;

  // Bus controller status codes.
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_MT_ADDR_ACK = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_MR_ADDR_ACK = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK = 8'h50;

  // Transfer modes.
  localparam logic [7:0] MODE_CTRL_LOW  = 8'h00;
  localparam logic [7:0] MODE_CTRL_HIGH = 8'h40;
  localparam logic [7:0] MODE_WR_RD     = 8'h01;

  // Start flag actions.
  localparam logic [1:0] STA_LEAVE      = 2'd0;
  localparam logic [1:0] STA_REQUEST    = 2'd1;
  localparam logic [1:0] STA_CLEAR      = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_MODE       = 2'd1;
  localparam logic [1:0] CFG_LENGTH     = 2'd2;

  // Largest byte count of a direct read.
  localparam int READ_LIMIT = 8;

  typedef struct packed {
    logic       load_tx;
    logic [7:0] tx_byte;
    logic [1:0] start_control;
    logic       stop_request;
    logic       ack_off;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [2:0] read_index;
    logic       busy_res;
    logic       fault;
  } result_t;

endpackage

// ===== rtl/smbseq_step.sv =====
// Next-state and result decode for one sequencer transaction.
// Depends on smbseq_pkg; instantiated by smbus_master_transfer_sequencer.
module smbseq_step #(
  parameter int BUFFER_DEPTH    = 8,
  parameter int READ_BACK_COUNT = 3,
  parameter int PW              = 4,
  parameter int RW              = 4
) (
  input  logic [1:0]          cmd,
  input  logic [7:0]          status_code,
  input  logic [7:0]          data_byte,
  input  logic [6:0]          slave_address,
  input  logic [7:0]          transfer_mode,
  input  logic [3:0]          transfer_length,
  input  logic                busy,
  input  logic [7:0]          address_byte,
  input  logic [PW-1:0]       send_pointer,
  input  logic [RW-1:0]       remaining_count,
  input  logic [2:0]          read_pointer,
  input  logic [7:0]          buffer_data,
  output smbseq_pkg::result_t res,
  output logic                busy_next,
  output logic [7:0]          address_byte_next,
  output logic [PW-1:0]       send_pointer_next,
  output logic [RW-1:0]       remaining_count_next,
  output logic [2:0]          read_pointer_next
);
  import smbseq_pkg::*;

  logic          prefix_mode;
  logic          have_left;
  logic [PW-1:0] sp_step;

  assign prefix_mode = (transfer_mode == MODE_CTRL_LOW) || (transfer_mode == MODE_CTRL_HIGH);
  assign have_left   = (remaining_count != '0);
  // The send pointer saturates one past the buffer end, where it reads as zero.
  assign sp_step     = (32'(send_pointer) < BUFFER_DEPTH) ? send_pointer + PW'(1) : send_pointer;

  always_comb begin
    res                  = '0;
    busy_next            = busy;
    address_byte_next    = address_byte;
    send_pointer_next    = send_pointer;
    remaining_count_next = remaining_count;
    read_pointer_next    = read_pointer;
    unique case (cmd)
      CMD_LOAD: begin
      end
      CMD_START_WR, CMD_START_RD: begin
        if (busy) begin
          res.fault = 1'b1;
        end else begin
          busy_next         = 1'b1;
          send_pointer_next = '0;
          read_pointer_next = '0;
          res.start_control = STA_REQUEST;
          if (cmd == CMD_START_WR) begin
            address_byte_next    = {slave_address, 1'b0};
            remaining_count_next = (32'(transfer_length) > BUFFER_DEPTH) ?
                                   RW'(BUFFER_DEPTH) : RW'(transfer_length);
          end else begin
            address_byte_next    = {slave_address, 1'b1};
            remaining_count_next = (32'(transfer_length) > READ_LIMIT) ?
                                   RW'(READ_LIMIT) : RW'(transfer_length);
          end
        end
      end
      CMD_STATUS: begin
        unique case (status_code)
          ST_START, ST_RESTART: begin
            res.load_tx = 1'b1;
            res.tx_byte = address_byte;
          end
          ST_MT_ADDR_ACK: begin
            res.start_control = STA_CLEAR;
            res.load_tx       = 1'b1;
            if (prefix_mode) begin
              res.tx_byte = transfer_mode;
            end else begin
              res.tx_byte = buffer_data;
              if (have_left) begin
                send_pointer_next    = sp_step;
                remaining_count_next = remaining_count - RW'(1);
              end
            end
          end
          ST_MT_DATA_ACK: begin
            if (transfer_mode == MODE_WR_RD) begin
              address_byte_next    = address_byte | 8'h01;
              remaining_count_next = RW'(READ_BACK_COUNT);
              read_pointer_next    = '0;
              res.start_control    = STA_REQUEST;
            end else if (have_left) begin
              res.load_tx          = 1'b1;
              res.tx_byte          = buffer_data;
              send_pointer_next    = sp_step;
              remaining_count_next = remaining_count - RW'(1);
            end else begin
              res.stop_request = 1'b1;
              busy_next        = 1'b0;
            end
          end
          ST_MR_ADDR_ACK: begin
            res.start_control = STA_CLEAR;
          end
          ST_MR_DATA_ACK: begin
            if (have_left) begin
              res.read_valid       = 1'b1;
              res.read_byte        = data_byte;
              res.read_index       = read_pointer;
              read_pointer_next    = read_pointer + 3'd1;
              remaining_count_next = remaining_count - RW'(1);
            end else begin
              res.ack_off = 1'b1;
            end
          end
          default: begin
            res.stop_request = 1'b1;
            res.fault        = 1'b1;
            busy_next        = 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
    res.busy_res = busy_next;
  end

endmodule

// ===== rtl/smbus_master_transfer_sequencer.sv =====
// SMBus master transfer sequencer top level: input stage, sequencer state,
// write buffer and result register. Depends on smbseq_pkg and smbseq_step.
//
// Usage: configuration is written through cfg_write, cfg_index and cfg_data
// (slave address, transfer mode, transfer length) while the block is idle.
// Each input transaction is a load, a start or a bus status event, taken when
// in_valid and in_ready are both high. Every input transaction yields exactly
// one result transaction on the output channel, in order, taken when
// out_valid and out_ready are both high.
// A transaction is captured in the input register, decoded in one pass of
// short logic against the sequencer state and written to the result
// register; out_valid rises when the result register takes it. One transaction
// per cycle is sustained while out_ready stays high.
// When the receiver stalls, the result register holds its transaction and
// the input register holds the next one; in_ready falls only when both are
// full. Reset clears the configuration, the sequencer state and both valid
// flags. The write buffer is not cleared; a slot must be loaded before it is
// sent.
module smbus_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH    = 8,
  parameter int READ_BACK_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [2:0] buffer_index,
  input  logic [7:0] status_code,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       load_tx,
  output logic [7:0] tx_byte,
  output logic [1:0] start_control,
  output logic       stop_request,
  output logic       ack_off,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic [2:0] read_index,
  output logic       busy_res,
  output logic       fault
);
  import smbseq_pkg::*;

  localparam int IW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW   = $clog2(BUFFER_DEPTH + 1);
  localparam int RMAX = (BUFFER_DEPTH > READ_LIMIT) ? BUFFER_DEPTH : READ_LIMIT;
  localparam int RW   = $clog2(RMAX + 1);

  logic [6:0]    slave_address;
  logic [7:0]    transfer_mode;
  logic [3:0]    transfer_length;

  logic          busy;
  logic [7:0]    address_byte;
  logic [PW-1:0] send_pointer;
  logic [RW-1:0] remaining_count;
  logic [2:0]    read_pointer;
  logic [7:0]    write_buffer [BUFFER_DEPTH];

  logic          s1_valid;
  logic [1:0]    s1_cmd;
  logic [2:0]    s1_bidx;
  logic [7:0]    s1_status;
  logic [7:0]    s1_data;

  result_t       result;
  result_t       res;
  logic          advance;
  logic [7:0]    buffer_data;

  logic          busy_next;
  logic [7:0]    address_byte_next;
  logic [PW-1:0] send_pointer_next;
  logic [RW-1:0] remaining_count_next;
  logic [2:0]    read_pointer_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address   <= '0;
      transfer_mode   <= '0;
      transfer_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR: slave_address   <= cfg_data[6:0];
        CFG_MODE:       transfer_mode   <= cfg_data;
        CFG_LENGTH:     transfer_length <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd    <= cmd;
      s1_bidx   <= buffer_index;
      s1_status <= status_code;
      s1_data   <= data_byte;
    end
  end

  assign buffer_data = (32'(send_pointer) < BUFFER_DEPTH) ?
                       write_buffer[send_pointer[IW-1:0]] : 8'h00;

  always_ff @(posedge clk) begin
    if (advance && (s1_cmd == CMD_LOAD) && (32'(s1_bidx) < BUFFER_DEPTH)) begin
      write_buffer[IW'(s1_bidx)] <= s1_data;
    end
  end

  smbseq_step #(
    .BUFFER_DEPTH   (BUFFER_DEPTH),
    .READ_BACK_COUNT(READ_BACK_COUNT),
    .PW             (PW),
    .RW             (RW)
  ) u_step (
    .cmd                 (s1_cmd),
    .status_code         (s1_status),
    .data_byte           (s1_data),
    .slave_address       (slave_address),
    .transfer_mode       (transfer_mode),
    .transfer_length     (transfer_length),
    .busy                (busy),
    .address_byte        (address_byte),
    .send_pointer        (send_pointer),
    .remaining_count     (remaining_count),
    .read_pointer        (read_pointer),
    .buffer_data         (buffer_data),
    .res                 (res),
    .busy_next           (busy_next),
    .address_byte_next   (address_byte_next),
    .send_pointer_next   (send_pointer_next),
    .remaining_count_next(remaining_count_next),
    .read_pointer_next   (read_pointer_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      address_byte    <= '0;
      send_pointer    <= '0;
      remaining_count <= '0;
      read_pointer    <= '0;
    end else if (advance) begin
      busy            <= busy_next;
      address_byte    <= address_byte_next;
      send_pointer    <= send_pointer_next;
      remaining_count <= remaining_count_next;
      read_pointer    <= read_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  assign load_tx       = result.load_tx;
  assign tx_byte       = result.tx_byte;
  assign start_control = result.start_control;
  assign stop_request  = result.stop_request;
  assign ack_off       = result.ack_off;
  assign read_valid    = result.read_valid;
  assign read_byte     = result.read_byte;
  assign read_index    = result.read_index;
  assign busy_res      = result.busy_res;
  assign fault         = result.fault;

  // A refused start never requests START.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fault && (start_control == STA_REQUEST)))
    else $error("refused start requested START");

  // A STOP always leaves the bus free.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && stop_request) |-> !busy_res)
    else $error("STOP reported with busy still set");

  // The send pointer never runs more than one past the buffer end.
  assert property (@(posedge clk) disable iff (rst)
    32'(send_pointer) <= BUFFER_DEPTH)
    else $error("send pointer beyond buffer end");

  // The input stage is refused only while both stages hold a transaction and the receiver stalls.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input refused without a stall");

endmodule
